### rtl/jac_pkg.sv
// Shared types and constants of the joystick axis conditioner.
`default_nettype none

package jac_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS = 3'd5;

    localparam int LOCKOUT_W     = 16;
    localparam int TIME_W        = 32;
    localparam int LOCKOUT_RESET = 20;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic capture;
        logic setup;
        logic axis;
        logic step;
        logic store;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/jac_ctrl.sv
// Sequencing controller of the joystick axis conditioner.
`default_nettype none

module jac_ctrl
    import jac_pkg::*;
#(
    parameter int FRACTION_BITS = 14
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic             r_axis, n_axis;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_axis  = AXIS_X;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt   = CNT_LAST;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_axis == AXIS_X) begin
                    n_axis  = AXIS_Y;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_X;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_stat.out_busy)
        else $error("result loaded while the output register is still held");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SETUP && r_axis == AXIS_X))
        else $error("accepted item did not start with the X axis");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_LAST))
        else $error("divider step count out of range");

    a_axis_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE && r_axis == AXIS_X) |=> (r_state == S_SETUP && r_axis == AXIS_Y))
        else $error("Y axis did not follow the X axis");

endmodule

`default_nettype wire

### rtl/jac_datapath.sv
// Datapath of the joystick axis conditioner: configuration, divider, debounce, output register.
`default_nettype none

module jac_datapath
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 14,
    parameter int CFG_W         = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]            i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample_x,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample_y,
    input  wire logic                        i_button_level,
    input  wire logic [TIME_W-1:0]           i_now_ms,
    input  wire t_dp_cmd                     i_cmd,
    output t_dp_stat                         o_stat,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic signed [FRACTION_BITS+1:0]  o_out_x,
    output logic signed [FRACTION_BITS+1:0]  o_out_y,
    output logic                             o_button
);

    localparam int SB = SAMPLE_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] FULL = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0] DZ_RESET = (FB+1)'((((1 << FB) * 75) + 500) / 1000);
    localparam logic [SB-1:0] MID_RESET = {1'b1, {(SB-1){1'b0}}};

    logic [SB-1:0]        r_center_x, r_center_y, r_range_x, r_range_y;
    logic [FB:0]          r_dz;
    logic [LOCKOUT_W-1:0] r_lockout;

    logic [SB-1:0]        r_samp_x, r_samp_y;
    logic                 r_raw;
    logic [TIME_W-1:0]    r_now;

    logic [SB:0]          r_rem;
    logic [SB-1:0]        r_rng;
    logic [FB:0]          r_quo;
    logic                 r_neg, r_zero, r_big, r_rzero;
    logic signed [FB+1:0] r_res_x, r_res_y;

    logic                 r_held;
    logic [TIME_W-1:0]    r_last_change;
    logic                 r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= MID_RESET;
            r_center_y <= MID_RESET;
            r_range_x  <= MID_RESET;
            r_range_y  <= MID_RESET;
            r_dz       <= DZ_RESET;
            r_lockout  <= LOCKOUT_W'(LOCKOUT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:   r_center_x <= i_cfg_data[SB-1:0];
                CFG_CENTER_Y:   r_center_y <= i_cfg_data[SB-1:0];
                CFG_RANGE_X:    r_range_x  <= i_cfg_data[SB-1:0];
                CFG_RANGE_Y:    r_range_y  <= i_cfg_data[SB-1:0];
                CFG_DEADZONE:   r_dz       <= i_cfg_data[FB:0];
                CFG_LOCKOUT_MS: r_lockout  <= i_cfg_data[LOCKOUT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SB-1:0] samp, cen, rng, mag;
    logic          neg;

    always_comb begin
        samp = (i_cmd.axis == AXIS_Y) ? r_samp_y  : r_samp_x;
        cen  = (i_cmd.axis == AXIS_Y) ? r_center_y : r_center_x;
        rng  = (i_cmd.axis == AXIS_Y) ? r_range_y : r_range_x;
        neg  = (samp < cen);
        mag  = neg ? (cen - samp) : (samp - cen);
    end

    logic          ge;
    logic [SB:0]   rem_sub;

    always_comb begin
        ge      = (r_rem >= {1'b0, r_rng});
        rem_sub = ge ? (r_rem - {1'b0, r_rng}) : r_rem;
    end

    logic [FB:0]          qv, mag_res;
    logic signed [FB+1:0] res;

    always_comb begin
        qv = r_rzero ? FULL : r_quo;
        if (r_zero) begin
            mag_res = '0;
        end else if (r_big) begin
            mag_res = FULL;
        end else if (qv < r_dz) begin
            mag_res = '0;
        end else if (qv > FULL) begin
            mag_res = FULL;
        end else begin
            mag_res = qv;
        end
        res = r_neg ? -$signed({1'b0, mag_res}) : $signed({1'b0, mag_res});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_samp_x <= i_sample_x;
            r_samp_y <= i_sample_y;
            r_raw    <= i_button_level;
            r_now    <= i_now_ms;
        end
        if (i_cmd.setup) begin
            r_rem   <= {1'b0, mag};
            r_rng   <= rng;
            r_quo   <= '0;
            r_neg   <= neg;
            r_zero  <= (mag == '0);
            r_rzero <= (rng == '0);
            r_big   <= (rng != '0) && ({1'b0, mag} >= {rng, 1'b0});
        end else if (i_cmd.step) begin
            r_rem <= {rem_sub[SB-1:0], 1'b0};
            r_quo <= {r_quo[FB-1:0], ge};
        end
        if (i_cmd.store) begin
            if (i_cmd.axis == AXIS_Y) begin
                r_res_y <= res;
            end else begin
                r_res_x <= res;
            end
        end
    end

    logic [TIME_W-1:0] elapsed;
    logic              take;

    always_comb begin
        elapsed = r_now - r_last_change;
        take    = (r_raw != r_held) && (elapsed > {{(TIME_W-LOCKOUT_W){1'b0}}, r_lockout});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_last_change <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (take) begin
                    r_held        <= r_raw;
                    r_last_change <= r_now;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_x  <= r_res_y;
            o_out_y  <= -r_res_x;
            o_button <= take ? r_raw : r_held;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

### rtl/joystick_axis_conditioner.sv
// Top level of the joystick axis conditioner.
//
// The slave stream takes one item per sample pair: both stick samples, the raw
// button level and a millisecond timestamp. The master stream returns one item
// per input item with both normalized axes, rotated by a quarter turn, and the
// debounced button level. A separate write channel sets the six calibration
// registers, and it is always ready.
// Each axis is divided by its range in one shared restoring divider that
// produces one quotient bit per cycle. A new item is taken only while the
// controller is idle, once the result of the last one has been loaded into
// the output register. The output register holds a result while the receiver
// stalls; the next item is accepted and worked on meanwhile, and its result
// waits until the held one is taken.
// Synchronous reset restores the default calibration, releases the button,
// clears the last change time and empties the output register.
`default_nettype none

module joystick_axis_conditioner
    import jac_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 14
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // sample_x, sample_y, button_level, now_ms, zero fill
    input  wire logic [((2*SAMPLE_BITS+TIME_W+1+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // out_x, out_y, button, zero fill
    output logic [((2*FRACTION_BITS+5+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [((SAMPLE_BITS > FRACTION_BITS+1) ?
                        ((SAMPLE_BITS > LOCKOUT_W) ? SAMPLE_BITS : LOCKOUT_W) :
                        ((FRACTION_BITS+1 > LOCKOUT_W) ? FRACTION_BITS+1 : LOCKOUT_W))-1:0]
                                           i_cfg_data
);

    localparam int SB        = SAMPLE_BITS;
    localparam int FB        = FRACTION_BITS;
    localparam int OUT_W     = 2*(FB+2) + 1;
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8;
    localparam int CFG_W     = $bits(i_cfg_data);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic signed [FB+1:0] out_x, out_y;
    logic                 button;

    assign o_cfg_ready = 1'b1;

    jac_ctrl #(
        .FRACTION_BITS (FB)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    jac_datapath #(
        .SAMPLE_BITS   (SB),
        .FRACTION_BITS (FB),
        .CFG_W         (CFG_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_x     (i_s_axis_tdata[SB-1:0]),
        .i_sample_y     (i_s_axis_tdata[2*SB-1:SB]),
        .i_button_level (i_s_axis_tdata[2*SB]),
        .i_now_ms       (i_s_axis_tdata[2*SB+TIME_W:2*SB+1]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_x        (out_x),
        .o_out_y        (out_y),
        .o_button       (button)
    );

    assign o_m_axis_tdata = {{(OUT_TW-OUT_W){1'b0}}, button, out_y, out_x};

endmodule

`default_nettype wire
